[src/mts_pkg.sv]
// Shared types, codes and defaults for the melody tone sequencer.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

	localparam int NOTE_DEPTH_DEF = 256;
	localparam int BASE_RATE_DEF  = 1000;

	localparam int FREQ_W  = 16;
	localparam int LEN_W   = 16;
	localparam int TICK_W  = 24;
	localparam int COUNT_W = 9;
	localparam int SLOT_W  = 8;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_START = 2'd2,
		REQ_STOP  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK,
		ST_DIV
	} mts_state_t;

	// One stored note, frequency in the lowest bits
	typedef struct packed {
		logic [TICK_W-1:0] start_tick;
		logic [LEN_W-1:0]  length;
		logic [FREQ_W-1:0] frequency;
	} note_entry_t;

	// Slave-side data beat, last field in the lowest bits
	typedef struct packed {
		logic [6:0]         pad;
		logic [COUNT_W-1:0] note_count;
		logic [TICK_W-1:0]  note_start_tick;
		logic [LEN_W-1:0]   note_length;
		logic [FREQ_W-1:0]  note_frequency;
		logic [SLOT_W-1:0]  note_slot;
	} in_beat_t;

	// Master-side data beat, last field in the lowest bits
	typedef struct packed {
		logic [3:0]         pad;
		logic               melody_done;
		logic [LEN_W-1:0]   ticks_left;
		logic [COUNT_W-1:0] note_position;
		logic               playing;
		logic               tone_active;
		logic [FREQ_W-1:0]  reload_value;
	} out_beat_t;

endpackage

`default_nettype wire

[src/mts_divider.sv]
// Restoring divider: constant BASE_RATE squared over a 16-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module mts_divider
	import mts_pkg::*;
#(
	parameter int BASE_RATE = BASE_RATE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FREQ_W-1:0] divisor,
	output logic                   done,
	output logic [FREQ_W-1:0]      quotient
);

	localparam int DIVIDEND = BASE_RATE * BASE_RATE;
	localparam int DW       = $clog2(DIVIDEND + 1);
	localparam int CW       = $clog2(DW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     dsr_q;
	logic [DW-1:0]     quot_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] div_q;

	logic [FREQ_W:0]   rem_sh;
	logic              ge;
	logic [FREQ_W:0]   rem_n;

	always_comb begin
		rem_sh = {rem_q, dsr_q[DW-1]};
		ge     = rem_sh >= {1'b0, div_q};
		rem_n  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// Payload: load on start, then shift one quotient bit in per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q  <= DW'(DIVIDEND);
			quot_q <= '0;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			dsr_q  <= dsr_q << 1;
			quot_q <= {quot_q[DW-2:0], ge};
			rem_q  <= rem_n[FREQ_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = FREQ_W'(quot_q);

endmodule

`default_nettype wire

[src/melody_tone_sequencer.sv]
// Melody tone sequencer top level: request decode, note store, tick sequencer.
//
//  Channel  Dir  Signals                          Beat contents
//  s_*      in   s_tvalid s_tready s_tdata s_tuser  one request (tick, note write, start, stop)
//  m_*      out  m_tvalid m_tready m_tdata          player status after that request
//  cfg_*    in   cfg_wr_en cfg_wr_data              sound_enable register, write only
//
//  A note write, start, stop, or a tick while stopped or muted is answered straight from idle.
//  A tick that finds its note not yet due, or a rest or end marker, is answered from the check.
//  A tick that loads a note waits for one note store read, then the one-bit-a-cycle divider.
//  Reset clears the player state and sets sound_enable; the note store is not cleared.
//  A new request is taken only when the sequencer is idle and the status beat has gone.
`timescale 1ns / 1ps
`default_nettype none

module melody_tone_sequencer
	import mts_pkg::*;
#(
	parameter int NOTE_DEPTH = NOTE_DEPTH_DEF,
	parameter int BASE_RATE  = BASE_RATE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// note_slot[7:0], note_frequency[23:8], note_length[39:24],
	// note_start_tick[63:40], note_count[72:64], zero[79:73]
	input  wire logic [79:0] s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]  s_tuser,
	// status stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// reload_value[15:0], tone_active[16], playing[17], note_position[26:18],
	// ticks_left[42:27], melody_done[43], zero[47:44]
	output logic [47:0]      m_tdata,
	// sound_enable register
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data
);

	localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

	// sequencer and player state
	mts_state_t         state_q, state_d;
	logic               m_tvalid_q;
	logic               done_q;
	logic               sound_enable_q;
	logic               playing_q;
	logic [TICK_W-1:0]  elapsed_q;
	logic [COUNT_W-1:0] cur_idx_q;
	logic [SLOT_W-1:0]  last_q;
	logic [LEN_W-1:0]   dur_q;
	logic [FREQ_W-1:0]  period_q;

	// note store
	note_entry_t        mem_q [NOTE_DEPTH];
	note_entry_t        rd_q;

	in_beat_t           in_beat;
	out_beat_t          out_beat;
	req_type_t          req;
	logic               in_acc;
	logic               slot_ok;
	logic               mem_we;
	logic               idx_ok;
	note_entry_t        note_eff;
	logic               due;
	logic               load_needed;
	logic [COUNT_W-1:0] nxt_idx;
	logic               ends;
	logic [SLOT_W-1:0]  start_last;

	logic               tick_go;
	logic               div_start;
	logic               div_done;
	logic [FREQ_W-1:0]  div_quot;
	logic               load_note;
	logic               advance;
	logic               finish;
	logic               imm_done;

	assign in_beat  = in_beat_t'(s_tdata);
	assign req      = req_type_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;

	// Drop writes aimed past the end of the store
	assign slot_ok = int'(in_beat.note_slot) < NOTE_DEPTH;
	assign mem_we  = in_acc && (req == REQ_WRITE) && slot_ok;

	// An index past the store reads as an all-zero entry
	assign idx_ok   = int'(cur_idx_q) < NOTE_DEPTH;
	assign note_eff = idx_ok ? rd_q : '0;

	assign due         = elapsed_q >= note_eff.start_tick;
	assign load_needed = (cur_idx_q < {1'b0, last_q}) && (note_eff.frequency != '0);
	assign nxt_idx     = cur_idx_q + COUNT_W'(1);
	assign ends        = nxt_idx > {1'b0, last_q};

	// Counts above the store limit clamp to the full 256 entries
	assign start_last = (in_beat.note_count > COUNT_W'(256)) ? {SLOT_W{1'b1}}
	                  : SLOT_W'(in_beat.note_count - COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Sequencer: one tick walks through store read, due check and, for a sounding
	// note, the divider
	always_comb begin
		state_d   = state_q;
		tick_go   = 1'b0;
		div_start = 1'b0;
		load_note = 1'b0;
		advance   = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (req == REQ_TICK) && playing_q && sound_enable_q) begin
					tick_go = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (!due) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else if (load_needed) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					advance = 1'b1;
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					load_note = 1'b1;
					advance   = 1'b1;
					finish    = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Every request but a live tick answers at once
	assign imm_done = in_acc && !tick_go;

	mts_divider #(
		.BASE_RATE (BASE_RATE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (note_eff.frequency),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sound_enable_q <= 1'b1;
		else if (cfg_wr_en)
			sound_enable_q <= cfg_wr_data;
	end

	// Player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			elapsed_q <= '0;
			cur_idx_q <= '0;
			last_q    <= '0;
			dur_q     <= '0;
			period_q  <= '0;
		end else if (in_acc) begin
			case (req)
				REQ_TICK: begin
					if (tick_go) begin
						// count down the sounding note, silence it at zero
						if (dur_q != '0) begin
							dur_q <= dur_q - LEN_W'(1);
							if (dur_q == LEN_W'(1))
								period_q <= '0;
						end
						if (elapsed_q != TICK_MAX)
							elapsed_q <= elapsed_q + TICK_W'(1);
					end
				end
				REQ_START: begin
					elapsed_q <= '0;
					cur_idx_q <= '0;
					dur_q     <= '0;
					period_q  <= '0;
					if (in_beat.note_count != '0) begin
						last_q    <= start_last;
						playing_q <= 1'b1;
					end else begin
						last_q    <= '0;
						playing_q <= 1'b0;
					end
				end
				REQ_STOP: begin
					playing_q <= 1'b0;
					elapsed_q <= '0;
					cur_idx_q <= '0;
					last_q    <= '0;
					dur_q     <= '0;
					period_q  <= '0;
				end
				default: ;
			endcase
		end else begin
			if (load_note) begin
				period_q <= div_quot;
				dur_q    <= note_eff.length;
			end
			if (advance) begin
				if (ends) begin
					// end marker reached: clear as for stop
					playing_q <= 1'b0;
					elapsed_q <= '0;
					cur_idx_q <= '0;
					last_q    <= '0;
					dur_q     <= '0;
					period_q  <= '0;
				end else begin
					cur_idx_q <= nxt_idx;
				end
			end
		end
	end

	// Status beat: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (imm_done || finish)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (imm_done)
				done_q <= 1'b0;
			else if (finish)
				done_q <= advance && ends;
		end
	end

	// Note store; the read port follows the awaited entry
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[AW'(in_beat.note_slot)] <= '{
				start_tick: in_beat.note_start_tick,
				length:     in_beat.note_length,
				frequency:  in_beat.note_frequency
			};
		rd_q <= mem_q[AW'(cur_idx_q)];
	end

	always_comb begin
		out_beat               = '0;
		out_beat.reload_value  = period_q;
		out_beat.tone_active   = playing_q && (period_q != '0);
		out_beat.playing       = playing_q;
		out_beat.note_position = cur_idx_q;
		out_beat.ticks_left    = dur_q;
		out_beat.melody_done   = done_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 48'(out_beat);

	// The awaited entry never runs past the end marker
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> (cur_idx_q <= {1'b0, last_q}))
		else $error("note index past end marker");

	// The divider only reports while the sequencer waits for it
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	// A stopped player keeps no tone and no countdown
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!playing_q |-> ((period_q == '0) && (dur_q == '0)))
		else $error("tone left over while stopped");

	// Melody end leaves the player cleared
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && done_q) |-> (!playing_q && (cur_idx_q == '0) && (elapsed_q == '0)))
		else $error("melody end without clearing");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the melody tone sequencer: directed and random request streams against a predictor.
`timescale 1ns / 1ps

module testbench;
	import mts_pkg::*;

	// Slack after the last status beat; the longest request is a note load
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_CYCLES  = 400;

	typedef struct {
		req_type_t kind;
		in_beat_t  beat;
	} pending_req_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        cfg_wr_en;
	logic        cfg_wr_data;

	// Requests waiting for the driver, and status beats still owed by the block
	pending_req_t req_fifo[$];
	out_beat_t    status_due[$];

	// Predicted player state
	logic [FREQ_W-1:0]  tbl_freq [NOTE_DEPTH_DEF];
	logic [LEN_W-1:0]   tbl_len [NOTE_DEPTH_DEF];
	logic [TICK_W-1:0]  tbl_start [NOTE_DEPTH_DEF];
	logic               sound_on;
	logic [TICK_W-1:0]  elapsed;
	logic [COUNT_W-1:0] next_idx;
	logic [SLOT_W-1:0]  final_idx;
	logic [LEN_W-1:0]   dur_left;
	logic [FREQ_W-1:0]  reload;
	logic               active;

	// Slots the request stream has written so far; melodies never reach past them
	bit slot_used [NOTE_DEPTH_DEF];

	int unsigned queued;
	int unsigned beats_sent;
	int unsigned results_seen;
	int unsigned melodies_ended;
	int unsigned mismatches;
	int unsigned hold_left;
	bit          hold_done;
	pending_req_t cur_req;

	melody_tone_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Halt playback and silence the tone
	function automatic void stop_player();
		active    = 1'b0;
		elapsed   = '0;
		next_idx  = '0;
		final_idx = '0;
		dur_left  = '0;
		reload    = '0;
	endfunction

	// Apply one request to the predicted player and return the status it leaves
	function automatic out_beat_t play_request(req_type_t kind, in_beat_t b);
		out_beat_t         r;
		logic [COUNT_W-1:0] idx;
		logic [COUNT_W-1:0] cnt;
		logic [31:0]       quot;
		logic              ended;
		r     = '0;
		ended = 1'b0;
		case (kind)
			REQ_TICK: begin
				if (active && sound_on) begin
					// count down the sounding note first, silence it on zero
					if (dur_left != 0) begin
						dur_left = dur_left - 1'b1;
						if (dur_left == 0)
							reload = '0;
					end
					if (elapsed != TICK_MAX)
						elapsed = elapsed + 1'b1;
					idx = next_idx;
					if (elapsed >= tbl_start[idx[SLOT_W-1:0]]) begin
						// the final entry only marks the end time; a rest loads nothing
						if (idx < {1'b0, final_idx} && tbl_freq[idx[SLOT_W-1:0]] != 0) begin
							quot     = (BASE_RATE_DEF * BASE_RATE_DEF) / tbl_freq[idx[SLOT_W-1:0]];
							reload   = quot[FREQ_W-1:0];
							dur_left = tbl_len[idx[SLOT_W-1:0]];
						end
						next_idx = idx + 1'b1;
						if (next_idx > {1'b0, final_idx}) begin
							stop_player();
							ended = 1'b1;
						end
					end
				end
			end
			REQ_WRITE: begin
				tbl_freq[b.note_slot]  = b.note_frequency;
				tbl_len[b.note_slot]   = b.note_length;
				tbl_start[b.note_slot] = b.note_start_tick;
			end
			REQ_START: begin
				// oversized counts clamp to a full table; zero acts as stop
				cnt = (b.note_count > 9'd256) ? 9'd256 : b.note_count;
				stop_player();
				if (cnt != 0) begin
					final_idx = SLOT_W'(cnt - 1'b1);
					active    = 1'b1;
				end
			end
			default: begin
				stop_player();
			end
		endcase
		r.reload_value  = reload;
		r.tone_active   = active && (reload != 0);
		r.playing       = active;
		r.note_position = next_idx;
		r.ticks_left    = dur_left;
		r.melody_done   = ended;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------

	// Fill every field but the pad at random so unused fields still toggle
	function automatic in_beat_t rand_beat();
		in_beat_t b;
		b                 = '0;
		b.note_slot       = SLOT_W'($urandom);
		b.note_frequency  = FREQ_W'($urandom);
		b.note_length     = LEN_W'($urandom);
		b.note_start_tick = TICK_W'($urandom);
		b.note_count      = COUNT_W'($urandom);
		return b;
	endfunction

	task automatic push_req(req_type_t kind, in_beat_t b);
		pending_req_t p;
		p.kind = kind;
		p.beat = b;
		req_fifo.push_back(p);
		queued++;
		if (kind == REQ_WRITE)
			slot_used[b.note_slot] = 1'b1;
	endtask

	task automatic push_write(int slot, int freq, int len, int start);
		in_beat_t b;
		b                 = rand_beat();
		b.note_slot       = SLOT_W'(slot);
		b.note_frequency  = FREQ_W'(freq);
		b.note_length     = LEN_W'(len);
		b.note_start_tick = TICK_W'(start);
		push_req(REQ_WRITE, b);
	endtask

	task automatic push_start(int count);
		in_beat_t b;
		b            = rand_beat();
		b.note_count = COUNT_W'(count);
		push_req(REQ_START, b);
	endtask

	task automatic push_ticks(int n);
		for (int k = 0; k < n; k++)
			push_req(REQ_TICK, rand_beat());
	endtask

	task automatic push_stop();
		push_req(REQ_STOP, rand_beat());
	endtask

	// Number of leading slots written; a random start asks for no more than this unless all are written
	function automatic int written_lead();
		int n;
		n = 0;
		while (n < NOTE_DEPTH_DEF && slot_used[n])
			n++;
		return n;
	endfunction

	function automatic int pick_freq();
		int roll;
		roll = $urandom_range(9);
		case (roll)
			0:       return 0;
			1:       return $urandom_range(1, 15);
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(100, 4000);
		endcase
	endfunction

	function automatic int pick_len();
		return ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
	endfunction

	// Load a short melody into the bottom slots, start it and tick it through,
	// now and then breaking in with a stop, a restart or a stray note write
	task automatic queue_melody();
		int n;
		int t;
		int ticks;
		int roll;
		n = $urandom_range(1, 8);
		t = $urandom_range(0, 3);
		for (int k = 0; k < n; k++) begin
			push_write(k, pick_freq(), pick_len(), t);
			t += $urandom_range(0, 5);
		end
		push_start(($urandom_range(9) == 0) ? $urandom_range(1, n) : n);
		ticks = t + $urandom_range(1, 4);
		for (int k = 0; k < ticks; k++) begin
			roll = $urandom_range(99);
			if (roll < 2) begin
				push_stop();
				break;
			end
			if (roll < 4)
				push_start(n);
			else if (roll < 6)
				push_write($urandom_range(8, 255), pick_freq(), pick_len(),
					$urandom_range(0, 20));
			push_ticks(1);
		end
	endtask

	// A few requests of any kind with random contents
	task automatic queue_noise();
		int lead;
		int roll;
		for (int k = $urandom_range(1, 6); k > 0; k--) begin
			roll = $urandom_range(3);
			lead = written_lead();
			case (roll)
				0: push_ticks(1);
				1: push_req(REQ_WRITE, rand_beat());
				2: push_start((lead == NOTE_DEPTH_DEF) ? $urandom_range(0, 511)
					: $urandom_range(0, lead));
				default: push_stop();
			endcase
		end
	endtask

	task automatic queue_random(int unsigned target);
		while (queued < target) begin
			if ($urandom_range(3) != 0)
				queue_melody();
			else
				queue_noise();
		end
	endtask

	// Hold until the block has answered everything, then let it settle
	task automatic drain();
		while (req_fifo.size() != 0 || s_tvalid || status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sound_enable(bit v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		sound_on     = v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Driver: offer queued requests, idling now and then except in a quiet window
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive
		bit gap;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				status_due.push_back(play_request(cur_req.kind, cur_req.beat));
				beats_sent++;
			end
			if (!s_tvalid || s_tready) begin
				gap = ($urandom_range(99) < 12) && !(beats_sent >= 400 && beats_sent < 700);
				if (req_fifo.size() != 0 && !gap) begin
					cur_req = req_fifo.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_req.kind;
					s_tdata  <= cur_req.beat;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Hold the status stream off once for a long stretch so the block backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= 300) begin
				hold_left <= STALL_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: compare each status beat with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		out_beat_t want;
		out_beat_t got;
		bit        gap;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (got.melody_done)
					melodies_ended++;
				if (status_due.size() == 0) begin
					mismatches++;
					$display("%0t: status beat with none expected, expected nothing, got %h",
						$time, m_tdata);
				end else begin
					want = status_due.pop_front();
					check_field("reload_value", want.reload_value, got.reload_value);
					check_field("tone_active", want.tone_active, got.tone_active);
					check_field("playing", want.playing, got.playing);
					check_field("note_position", want.note_position, got.note_position);
					check_field("ticks_left", want.ticks_left, got.ticks_left);
					check_field("melody_done", want.melody_done, got.melody_done);
				end
			end
			gap = ($urandom_range(99) < 12) && !(results_seen >= 900 && results_seen < 1200);
			m_tready <= (hold_left == 0) && !gap;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of phases
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = REQ_TICK;
		m_tready    = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		sound_on    = 1'b1;
		stop_player();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_sound_enable(1'b1);

		// Directed: idle requests, a melody with a rest and both frequency
		// extremes, a stop mid-play, a restart and a one-entry melody
		push_ticks(1);
		push_stop();
		push_start(0);
		push_write(0, 1, 2, 1);
		push_write(1, 0, 7, 2);
		push_write(2, 65535, 65535, 3);
		push_write(3, 1000, 0, 5);
		push_write(255, 65535, 65535, 16777215);
		push_start(4);
		push_ticks(5);
		push_start(4);
		push_ticks(2);
		push_start(4);
		push_ticks(1);
		push_stop();
		push_ticks(1);
		push_start(1);
		push_ticks(1);
		drain();

		queue_random(520);
		drain();

		// Muted: ticks must leave playback frozen
		write_sound_enable(1'b0);
		queue_random(640);
		drain();
		write_sound_enable(1'b1);

		// Full table, one entry per tick, started with an oversized count
		for (int k = 0; k < NOTE_DEPTH_DEF; k++)
			push_write(k, pick_freq(), $urandom_range(0, 3), k);
		push_start(511);
		push_ticks(NOTE_DEPTH_DEF + 2);
		queue_random(queued + 300);
		drain();

		$display("Sent %0d requests and checked %0d status beats; %0d melodies played out.",
			beats_sent, results_seen, melodies_ended);
		$display("Phases: directed, random, muted, full table with oversized count, random.");
		if (mismatches == 0) begin
			$display("** melody_tone_sequencer: PASSED **");
		end else begin
			$display("** melody_tone_sequencer: FAILED **");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run
	initial begin
		#1_000_000;
		$display("** melody_tone_sequencer: FAILED **");
		$finish;
	end

endmodule

[files.f]
src/mts_pkg.sv
src/mts_divider.sv
src/melody_tone_sequencer.sv
sim/testbench.sv
